// File: rtl/core/rgbhsv_pkg.sv
package rgbhsv_pkg;

    // Hue sector picked by the largest channel, red first on ties
    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

endpackage

// File: rtl/core/rgb_to_hsv_converter.sv
// RGB to HSV pixel converter. Takes one pixel per clock while m_ready is high and
// gives hue and saturation as FRACTION_BITS-bit fractions (truncated, saturation
// of 1.0 clamps to all ones) and brightness as the largest channel. Hue and
// saturation come from two restoring dividers that share one pipeline, one
// quotient bit per stage; a request passes the front stage, the setup slot and
// the quotient slots to the result. Each stage moves on when its successor has
// room, so empty slots collapse under m_ready stalls and s_ready stays high
// while the pipeline still has a hole.
module rgb_to_hsv_converter #(
    parameter int PIXEL_BITS    = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [PIXEL_BITS-1:0]    s_red,
    input  logic [PIXEL_BITS-1:0]    s_green,
    input  logic [PIXEL_BITS-1:0]    s_blue,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [FRACTION_BITS-1:0] m_hue,
    output logic [FRACTION_BITS-1:0] m_saturation,
    output logic [PIXEL_BITS-1:0]    m_brightness
);
    import rgbhsv_pkg::*;

    localparam int PW = PIXEL_BITS;
    localparam int FW = FRACTION_BITS;
    localparam int DW = PIXEL_BITS + 3;   // holds 6 * chroma

    typedef struct packed {
        logic          gray;
        logic          sat_int;
        logic [PW-1:0] v;
        logic [PW-1:0] rem_s;
        logic [DW-1:0] rem_h;
        logic [DW-1:0] div_h;
        logic [FW-1:0] q_s;
        logic [FW-1:0] q_h;
    } stage_t;

    // front stage: channels, max and chroma
    logic          s0_valid_reg;
    logic [PW-1:0] s0_r_reg, s0_g_reg, s0_b_reg, s0_v_reg, s0_c_reg;
    logic [PW-1:0] mx_rg, mn_rg, v_next, mn_next;
    logic          s0_en;

    // divider pipeline: slot 0 is setup, slots 1..FW one quotient bit each
    stage_t pipe_reg [0:FW];
    stage_t pipe_next[0:FW];
    logic   pv_reg   [0:FW];
    logic   en       [0:FW];

    always_comb begin
        mx_rg   = (s_red > s_green) ? s_red : s_green;
        mn_rg   = (s_red < s_green) ? s_red : s_green;
        v_next  = (mx_rg > s_blue) ? mx_rg : s_blue;
        mn_next = (mn_rg < s_blue) ? mn_rg : s_blue;
    end

    assign s0_en   = !s0_valid_reg || en[0];
    assign s_ready = s0_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (s0_en) begin
            s0_valid_reg <= s_valid;
        end
        if (s0_en && s_valid) begin
            s0_r_reg <= s_red;
            s0_g_reg <= s_green;
            s0_b_reg <= s_blue;
            s0_v_reg <= v_next;
            s0_c_reg <= v_next - mn_next;
        end
    end

    // setup: angle numerator, 6c divisor, integer step of c / v
    sector_t       sector;
    logic [DW-1:0] c_ext, six_c, num;

    always_comb begin
        c_ext = DW'(s0_c_reg);
        six_c = (c_ext << 2) + (c_ext << 1);
        if (s0_v_reg == s0_r_reg) begin
            sector = SECTOR_RED;
        end else if (s0_v_reg == s0_g_reg) begin
            sector = SECTOR_GREEN;
        end else begin
            sector = SECTOR_BLUE;
        end
        unique case (sector)
            SECTOR_RED: begin
                // negative angle wraps by a full turn
                if (s0_g_reg >= s0_b_reg) begin
                    num = DW'(s0_g_reg - s0_b_reg);
                end else begin
                    num = six_c - DW'(s0_b_reg - s0_g_reg);
                end
            end
            SECTOR_GREEN: num = (c_ext << 1) + DW'(s0_b_reg) - DW'(s0_r_reg);
            SECTOR_BLUE:  num = (c_ext << 2) + DW'(s0_r_reg) - DW'(s0_g_reg);
            default:      num = '0;
        endcase

        pipe_next[0].gray    = (s0_c_reg == '0);
        pipe_next[0].sat_int = (s0_c_reg >= s0_v_reg);
        pipe_next[0].v       = s0_v_reg;
        pipe_next[0].rem_s   = (s0_c_reg >= s0_v_reg) ? s0_c_reg - s0_v_reg : s0_c_reg;
        pipe_next[0].rem_h   = num;
        pipe_next[0].div_h   = six_c;
        pipe_next[0].q_s     = '0;
        pipe_next[0].q_h     = '0;
    end

    genvar k;
    generate
        for (k = 1; k <= FW; k++) begin : g_div
            logic [PW:0] rs2;
            logic [DW:0] rh2;
            logic        bit_s, bit_h;

            always_comb begin
                rs2   = {pipe_reg[k-1].rem_s, 1'b0};
                rh2   = {pipe_reg[k-1].rem_h, 1'b0};
                bit_s = (rs2 >= {1'b0, pipe_reg[k-1].v});
                bit_h = (rh2 >= {1'b0, pipe_reg[k-1].div_h});

                pipe_next[k]       = pipe_reg[k-1];
                pipe_next[k].rem_s = bit_s ? PW'(rs2 - {1'b0, pipe_reg[k-1].v})
                                           : PW'(rs2);
                pipe_next[k].rem_h = bit_h ? DW'(rh2 - {1'b0, pipe_reg[k-1].div_h})
                                           : DW'(rh2);
                pipe_next[k].q_s   = {pipe_reg[k-1].q_s[FW-2:0], bit_s};
                pipe_next[k].q_h   = {pipe_reg[k-1].q_h[FW-2:0], bit_h};
            end
        end

        for (k = 0; k <= FW; k++) begin : g_stage
            logic in_valid;

            if (k == 0) begin : g_first
                assign in_valid = s0_valid_reg;
            end else begin : g_rest
                assign in_valid = pv_reg[k-1];
            end

            if (k == FW) begin : g_last
                assign en[k] = !pv_reg[k] || m_ready;
            end else begin : g_mid
                assign en[k] = !pv_reg[k] || en[k+1];
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    pv_reg[k] <= 1'b0;
                end else if (en[k]) begin
                    pv_reg[k] <= in_valid;
                end
                if (en[k] && in_valid) begin
                    pipe_reg[k] <= pipe_next[k];
                end
            end
        end
    endgenerate

    // gray (and black) pixels force hue and saturation to zero
    assign m_valid      = pv_reg[FW];
    assign m_brightness = pipe_reg[FW].v;
    assign m_hue        = pipe_reg[FW].gray ? '0 : pipe_reg[FW].q_h;
    assign m_saturation = pipe_reg[FW].gray    ? '0 :
                          pipe_reg[FW].sat_int ? '1 : pipe_reg[FW].q_s;

endmodule

// File: rtl/core/rgbhsv_chk.sv
module rgbhsv_chk #(
    parameter int PIXEL_BITS    = 8,
    parameter int FRACTION_BITS = 16
) (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic [PIXEL_BITS-1:0]    s_red,
    input logic [PIXEL_BITS-1:0]    s_green,
    input logic [PIXEL_BITS-1:0]    s_blue,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [FRACTION_BITS-1:0] m_hue,
    input logic [FRACTION_BITS-1:0] m_saturation,
    input logic [PIXEL_BITS-1:0]    m_brightness
);

    // result held steady while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hue)
            && $stable(m_saturation) && $stable(m_brightness))
        else $error("result changed while stalled");

    // pipeline empties on reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // black pixel has no hue and no saturation
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_brightness == '0) |-> (m_hue == '0) && (m_saturation == '0))
        else $error("black pixel with nonzero hue or saturation");

    // with the output free, the pipeline always has room for a request
    a_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked while output is empty");

endmodule

bind rgb_to_hsv_converter rgbhsv_chk #(
    .PIXEL_BITS   (PIXEL_BITS),
    .FRACTION_BITS(FRACTION_BITS)
) u_rgbhsv_chk (.*);

// File: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbhsv_pkg::*;

    localparam int PIX      = 8;
    localparam int FRAC     = 16;
    localparam int LATENCY  = FRAC + 2;
    localparam int FRAC_MAX = (1 << FRAC) - 1;
    localparam int PIX_MAX  = (1 << PIX) - 1;
    localparam int N_RANDOM = 1000;

    typedef struct {
        logic [FRAC-1:0] hue;
        logic [FRAC-1:0] saturation;
        logic [PIX-1:0]  brightness;
    } hsv_t;

    class hsv_scoreboard;
        hsv_t        pending[$];
        int unsigned mismatches;
        int unsigned pixels_in;
        int unsigned results_out;

        // Hexcone conversion in exact integer arithmetic, truncated quotients.
        function void note_pixel(input logic [PIX-1:0] r, g, b);
            hsv_t        want;
            int unsigned rv, gv, bv, v, mn, c, num, q;
            sector_t     sector;
            rv = 32'(r);
            gv = 32'(g);
            bv = 32'(b);
            v  = (rv > gv) ? rv : gv;
            v  = (v > bv) ? v : bv;
            mn = (rv < gv) ? rv : gv;
            mn = (mn < bv) ? mn : bv;
            c  = v - mn;
            want.brightness = v[PIX-1:0];
            want.saturation = '0;
            want.hue        = '0;
            if (v != 0) begin
                q = (c << FRAC) / v;
                want.saturation = (q > FRAC_MAX) ? FRAC_MAX[FRAC-1:0] : q[FRAC-1:0];
            end
            if (c != 0) begin
                if (v == rv)
                    sector = SECTOR_RED;
                else if (v == gv)
                    sector = SECTOR_GREEN;
                else
                    sector = SECTOR_BLUE;
                case (sector)
                    SECTOR_RED: begin
                        // offset by a full turn; drop it again if the angle was not negative
                        num = 6 * c + gv - bv;
                        if (num >= 6 * c)
                            num = num - 6 * c;
                    end
                    SECTOR_GREEN: num = 2 * c + bv - rv;
                    default:      num = 4 * c + rv - gv;
                endcase
                q = (num << FRAC) / (6 * c);
                want.hue = (q > FRAC_MAX) ? FRAC_MAX[FRAC-1:0] : q[FRAC-1:0];
            end
            pending.push_back(want);
            pixels_in++;
        endfunction

        function void check_result(input logic [FRAC-1:0] hue, saturation,
                                   input logic [PIX-1:0] brightness);
            hsv_t want;
            results_out++;
            if (pending.size() == 0) begin
                $error("result with no request outstanding: hue %0d saturation %0d %s %0d",
                       hue, saturation, "brightness", brightness);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (hue !== want.hue) begin
                $error("hue mismatch: expected %0d, actual %0d", want.hue, hue);
                mismatches++;
            end
            if (saturation !== want.saturation) begin
                $error("saturation mismatch: expected %0d, actual %0d",
                       want.saturation, saturation);
                mismatches++;
            end
            if (brightness !== want.brightness) begin
                $error("brightness mismatch: expected %0d, actual %0d",
                       want.brightness, brightness);
                mismatches++;
            end
        endfunction
    endclass

    logic            aclk         = 1'b0;
    logic            aresetn      = 1'b0;
    logic            s_valid      = 1'b0;
    logic            s_ready;
    logic [PIX-1:0]  s_red        = '0;
    logic [PIX-1:0]  s_green      = '0;
    logic [PIX-1:0]  s_blue       = '0;
    logic            m_valid;
    logic            m_ready      = 1'b0;
    logic [FRAC-1:0] m_hue;
    logic [FRAC-1:0] m_saturation;
    logic [PIX-1:0]  m_brightness;

    int unsigned send_idle_pct = 28;
    int unsigned recv_idle_pct = 66;

    hsv_scoreboard hsv_sb = new();

    // {red, green, blue}
    logic [3*PIX-1:0] corner_pixels [22] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,  // black, white, grays
        24'hFF0000, 24'h00FF00, 24'h0000FF,              // primaries
        24'hFFFF00, 24'h00FFFF, 24'hFF00FF,              // max ties pick red, then green
        24'hFF0001, 24'hC80A64, 24'h0A0009,              // red sector, negative angle wraps
        24'h64C832, 24'h3264C8, 24'hC83264,              // green, blue, red sectors
        24'h010000, 24'h000100, 24'h000001,              // smallest chroma, full saturation
        24'hFFFEFE, 24'hAA55AA, 24'h55AA55               // near-gray, alternating bits
    };

    rgb_to_hsv_converter #(
        .PIXEL_BITS    (PIX),
        .FRACTION_BITS (FRAC)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hue        (m_hue),
        .m_saturation (m_saturation),
        .m_brightness (m_brightness)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                hsv_sb.note_pixel(s_red, s_green, s_blue);
            if (m_valid && m_ready)
                hsv_sb.check_result(m_hue, m_saturation, m_brightness);
        end
    end

    task automatic send_pixel(input logic [3*PIX-1:0] rgb);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_red, s_green, s_blue} <= rgb;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Half uniform pixels, plus grays, max ties, full saturation, tiny chroma and channels at 0 or max.
    function automatic logic [3*PIX-1:0] random_pixel();
        logic [PIX-1:0] ch [3];
        int unsigned    base, top, odd;
        case ($urandom_range(9))
            5: begin
                base = $urandom_range(PIX_MAX);
                ch = '{PIX'(base), PIX'(base), PIX'(base)};
            end
            6: begin
                top = $urandom_range(1, PIX_MAX);
                odd = $urandom_range(2);
                for (int i = 0; i < 3; i++)
                    ch[i] = (i == odd) ? PIX'($urandom_range(top)) : PIX'(top);
            end
            7: begin
                odd = $urandom_range(2);
                for (int i = 0; i < 3; i++)
                    ch[i] = (i == odd) ? '0 : PIX'($urandom_range(PIX_MAX));
            end
            8: begin
                base = $urandom_range(PIX_MAX - 2);
                for (int i = 0; i < 3; i++)
                    ch[i] = PIX'(base + $urandom_range(2));
            end
            9: begin
                for (int i = 0; i < 3; i++)
                    ch[i] = ($urandom_range(1) != 0) ? PIX_MAX[PIX-1:0] : '0;
            end
            default: begin
                for (int i = 0; i < 3; i++)
                    ch[i] = PIX'($urandom_range(PIX_MAX));
            end
        endcase
        return {ch[0], ch[1], ch[2]};
    endfunction

    initial begin
        int unsigned drain;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (corner_pixels[i])
            send_pixel(corner_pixels[i]);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                send_idle_pct = 66;
                recv_idle_pct = 28;
            end else if (i == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_pixel(random_pixel());
        end
        s_valid <= 1'b0;

        drain = 0;
        while (hsv_sb.pending.size() != 0 && drain < 100000) begin
            @(posedge aclk);
            drain++;
        end
        if (hsv_sb.pending.size() != 0) begin
            $display("%0d requests never answered", hsv_sb.pending.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            repeat (4 * LATENCY) @(posedge aclk);
            $display("%0d pixels converted (corner colors, grays, ties, random), %0d results",
                     hsv_sb.pixels_in, hsv_sb.results_out);
            $display("three stall mixes on both sides, %0d field mismatches",
                     hsv_sb.mismatches);
            if (hsv_sb.mismatches == 0)
                $display("[ OK ] regression clean");
            else
                $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d requests outstanding", hsv_sb.pending.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
